// ===== design/shp3_pkg.sv =====
// Shared types, register indexes and the per-channel sharpen arithmetic.
package shp3_pkg;

	// One RGB pixel: red in bits 7..0, green 15..8, blue 23..16.
	localparam int unsigned PIX_W = 24;
	localparam int unsigned CHAN_W = 8;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 13;
	localparam int unsigned WIDTH_REG_W = 11;
	localparam int unsigned HEIGHT_REG_W = 13;
	localparam int unsigned ROW_W = 12;
	localparam int unsigned MAX_HEIGHT = 4096;
	localparam int unsigned WIDTH_RESET = 640;
	localparam int unsigned HEIGHT_RESET = 480;

	typedef logic [PIX_W-1:0] pixel_t;
	typedef logic [CHAN_W-1:0] chan_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1
	} cfg_reg_t;

	// The result is 5*c - u - d - l - r from the centre and its edge neighbours, clamped to 0..255.
	// The sum spans -1020..1275, so twelve signed bits are enough.
	function automatic chan_t sharpen_chan(input chan_t c, input chan_t u, input chan_t d,
			input chan_t l, input chan_t r);
		logic [11:0] s;
		chan_t res;
		s = {2'b00, c, 2'b00} + {4'b0000, c} - {4'b0000, u} - {4'b0000, d}
			- {4'b0000, l} - {4'b0000, r};
		if (s[11]) begin
			res = '0;
		end else if (s[10:8] != 3'b000) begin
			res = '1;
		end else begin
			res = s[7:0];
		end
		return res;
	endfunction

endpackage

// ===== design/sharpen_3x3_filter.sv =====
// Streaming 3x3 sharpen filter over RGB frames in raster order.
//
//  channel | direction | beat carries
//  --------+-----------+---------------------------------------------------------
//  s_*     | in        | tdata: pixel_red, pixel_green, pixel_blue
//  m_*     | out       | tdata: sharp_red, sharp_green, sharp_blue; tlast: frame_last
//  cfg_*   | in        | cfg_index selects image_width (0) or image_height (1)
//
// One pixel is taken every cycle while the output is not stalled. A pixel waits
// in stage one for its registered line store read, then its result goes to the
// output register. Reset clears the counters, the window and the output stage;
// the line store is not cleared, since a result only uses entries written by the
// two rows above it. A stalled output holds the filter stage, and with it the
// input side.
module sharpen_3x3_filter
	import shp3_pkg::*;
#(
	parameter int unsigned MAX_WIDTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [PIX_W-1:0]      s_tdata,    // pixel_red, pixel_green, pixel_blue
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [PIX_W-1:0]      m_tdata,    // sharp_red, sharp_green, sharp_blue
	output logic                  m_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned CMP_W = ((COL_W > WIDTH_REG_W) ? COL_W : WIDTH_REG_W) + 1;
	localparam logic [CMP_W-1:0] MAX_W_C = CMP_W'(MAX_WIDTH);

	// Configuration registers.
	logic [WIDTH_REG_W-1:0]  image_width_q;
	logic [HEIGHT_REG_W-1:0] image_height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_REG_W'(WIDTH_RESET);
			image_height_q <= HEIGHT_REG_W'(HEIGHT_RESET);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[WIDTH_REG_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[HEIGHT_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// Last column and row index, with the sizes saturated to their legal range.
	logic [CMP_W-1:0]        width_ext;
	logic [CMP_W-1:0]        width_eff;
	logic [CMP_W-1:0]        last_col_idx;
	logic [HEIGHT_REG_W-1:0] height_eff;
	logic [HEIGHT_REG_W-1:0] last_row_idx;

	always_comb begin
		width_ext = CMP_W'(image_width_q);
		if (width_ext < CMP_W'(3)) begin
			width_eff = CMP_W'(3);
		end else if (width_ext > MAX_W_C) begin
			width_eff = MAX_W_C;
		end else begin
			width_eff = width_ext;
		end
		last_col_idx = width_eff - CMP_W'(1);

		if (image_height_q < HEIGHT_REG_W'(3)) begin
			height_eff = HEIGHT_REG_W'(3);
		end else if (image_height_q > HEIGHT_REG_W'(MAX_HEIGHT)) begin
			height_eff = HEIGHT_REG_W'(MAX_HEIGHT);
		end else begin
			height_eff = image_height_q;
		end
		last_row_idx = height_eff - HEIGHT_REG_W'(1);
	end

	// Handshake and stage control.
	logic s_accept;
	logic valid_s1;
	logic emit_s1;
	logic last_s1;
	logic [COL_W-1:0] addr_s1;
	pixel_t bot_s1;
	logic s1_adv;
	logic out_valid_q;

	assign s1_adv   = valid_s1 && (!emit_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || s1_adv;
	assign s_accept = s_tvalid && s_tready;

	// Raster position of the next pixel.
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic last_col;
	logic last_row;

	assign last_col = CMP_W'(col_q) >= last_col_idx;
	assign last_row = HEIGHT_REG_W'(row_q) >= last_row_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (s_accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Stage one: the pixel waits for its column of the line store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			bot_s1  <= s_tdata;
			addr_s1 <= col_q;
			emit_s1 <= (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
			last_s1 <= last_col && last_row;
		end
	end

	// Line store: two previous rows per column, older row in the upper half.
	logic [2*PIX_W-1:0] rd_data;
	pixel_t top;
	pixel_t mid;

	assign top = rd_data[2*PIX_W-1:PIX_W];
	assign mid = rd_data[PIX_W-1:0];

	shp3_line_ram #(
		.DEPTH  (MAX_WIDTH),
		.DATA_W (2*PIX_W)
	) u_line_ram (
		.clk     (clk),
		.rd_en   (s_accept),
		.rd_addr (col_q),
		.rd_data (rd_data),
		.wr_en   (s1_adv),
		.wr_addr (addr_s1),
		.wr_data ({mid, bot_s1})
	);

	// Window: middle of the left column and all three of the centre column.
	pixel_t left_mid_q;
	pixel_t cen_top_q;
	pixel_t cen_mid_q;
	pixel_t cen_bot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_mid_q <= '0;
			cen_top_q  <= '0;
			cen_mid_q  <= '0;
			cen_bot_q  <= '0;
		end else if (s1_adv) begin
			left_mid_q <= cen_mid_q;
			cen_top_q  <= top;
			cen_mid_q  <= mid;
			cen_bot_q  <= bot_s1;
		end
	end

	// Sharpen each channel; the right neighbour is the middle of the new column.
	pixel_t sharp;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sharp[k*CHAN_W +: CHAN_W] = sharpen_chan(
				cen_mid_q[k*CHAN_W +: CHAN_W], cen_top_q[k*CHAN_W +: CHAN_W],
				cen_bot_q[k*CHAN_W +: CHAN_W], left_mid_q[k*CHAN_W +: CHAN_W],
				mid[k*CHAN_W +: CHAN_W]);
		end
	end

	// Output register.
	pixel_t out_data_q;
	logic   out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit_s1) begin
			out_data_q <= sharp;
			out_last_q <= last_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	// Two pixels in flight never share a column, so no forwarding is needed.
	a_no_same_col: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && s_accept) |-> (col_q != addr_s1))
		else $error("line store read and pending write hit the same column");

	// A held stage one keeps its pixel and column.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_adv) |=> (valid_s1 && $stable(addr_s1) && $stable(bot_s1)))
		else $error("stage one lost its pixel while stalled");

	// The frame's final pixel restarts the raster position.
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && last_col && last_row) |=> (col_q == '0 && row_q == '0))
		else $error("counters did not restart at the end of the frame");
`endif

endmodule

// ===== design/shp3_line_ram.sv =====
// Line store: single-port-write, single-port-read memory with a registered read.
module shp3_line_ram
	import shp3_pkg::*;
#(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned DATA_W = 48
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port; the data holds while no read is enabled.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the streaming 3x3 sharpen filter over RGB frames.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import shp3_pkg::*;

	// Register indexes that map to nothing; writes there must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_3 = 2'd3;
	localparam int unsigned LINE_DEPTH = 1024;
	localparam int unsigned RANDOM_PIXELS = 500;
	localparam int unsigned DRAIN_CYCLES = 8;

	typedef enum int {
		PIX_RANDOM,
		PIX_EXTREME,
		PIX_SMOOTH,
		PIX_MIXED
	} pix_style_t;

	// One expected output beat, channels unpacked.
	typedef struct {
		chan_t red;
		chan_t green;
		chan_t blue;
		logic  last;
	} sharp_beat_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [PIX_W-1:0]      s_tdata;    // pixel_red, pixel_green, pixel_blue
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [PIX_W-1:0]      m_tdata;    // sharp_red, sharp_green, sharp_blue
	logic                  m_tlast;    // frame_last
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Predictor state: registers, raster position, window and line store.
	logic [WIDTH_REG_W-1:0]  width_reg;
	logic [HEIGHT_REG_W-1:0] height_reg;
	logic [9:0]              pos_col;
	logic [ROW_W-1:0]        pos_row;
	pixel_t                  window_px[6];
	logic [2*PIX_W-1:0]      line_mem[LINE_DEPTH];

	sharp_beat_t sharp_queue[$];
	sharp_beat_t head_beat;
	int          fault_count = 0;
	int          pixels_sent = 0;
	int          src_gap_max = 0;
	int          snk_stall_max = 0;
	int          sink_hold = 0;

	sharpen_3x3_filter #(
		.MAX_WIDTH(1024)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// The result is 5*ctr - up - dn - lf - rt from the centre and its edge neighbours, clamped to a byte.
	function automatic chan_t sharpen_value(chan_t ctr, chan_t up, chan_t dn, chan_t lf,
			chan_t rt);
		int acc;
		acc = 5 * int'(ctr) - int'(up) - int'(dn) - int'(lf) - int'(rt);
		if (acc < 0) begin
			acc = 0;
		end else if (acc > 255) begin
			acc = 255;
		end
		return chan_t'(acc);
	endfunction

	function automatic pixel_t draw_pixel(pix_style_t style);
		pixel_t px;
		int     pick;
		pick = (style == PIX_MIXED) ? $urandom_range(0, 2) : int'(style);
		for (int k = 0; k < 3; k++) begin
			case (pick)
				PIX_EXTREME: begin
					px[8*k +: 8] = {8{1'($urandom_range(0, 1))}};
				end
				PIX_SMOOTH: begin
					px[8*k +: 8] = chan_t'($urandom_range(96, 160));
				end
				default: begin
					px[8*k +: 8] = chan_t'($urandom_range(0, 255));
				end
			endcase
		end
		return px;
	endfunction

	task automatic note_fault(input string msg);
		fault_count++;
		if (fault_count <= 10) begin
			$display("%0t: %s", $realtime, msg);
		end
	endtask

	// Advance the predictor by one accepted pixel and queue any result it yields.
	task automatic predict_pixel(input pixel_t bot);
		int unsigned        w;
		int unsigned        h;
		logic [2*PIX_W-1:0] entry;
		pixel_t             top;
		pixel_t             mid;
		bit                 last_col;
		bit                 last_row;
		sharp_beat_t        res;
		chan_t              ch[3];
		w = width_reg;
		h = height_reg;
		if (w < 3) w = 3;
		if (w > LINE_DEPTH) w = LINE_DEPTH;
		if (h < 3) h = 3;
		if (h > MAX_HEIGHT) h = MAX_HEIGHT;

		entry = line_mem[pos_col];
		top = entry[2*PIX_W-1:PIX_W];
		mid = entry[PIX_W-1:0];
		line_mem[pos_col] = {mid, bot};

		last_col = (pos_col >= w - 1);
		last_row = (pos_row >= h - 1);

		// Interior pixel one row up and one column left is now complete.
		if (pos_row >= 2 && pos_col >= 2) begin
			for (int k = 0; k < 3; k++) begin
				ch[k] = sharpen_value(window_px[4][8*k +: 8], window_px[3][8*k +: 8],
					window_px[5][8*k +: 8], window_px[1][8*k +: 8], mid[8*k +: 8]);
			end
			res.red = ch[0];
			res.green = ch[1];
			res.blue = ch[2];
			res.last = last_col && last_row;
			sharp_queue.push_back(res);
		end

		window_px[0] = window_px[3];
		window_px[1] = window_px[4];
		window_px[2] = window_px[5];
		window_px[3] = top;
		window_px[4] = mid;
		window_px[5] = bot;

		if (last_col) begin
			pos_col = '0;
			pos_row = last_row ? '0 : pos_row + 1'b1;
		end else begin
			pos_col = pos_col + 1'b1;
		end
	endtask

	// Send one pixel beat after a random gap; entered and left at a falling edge.
	task automatic send_pixel(input pixel_t px);
		int gap;
		gap = $urandom_range(0, src_gap_max);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= px;
		do @(posedge clk); while (!s_tready);
		predict_pixel(px);
		pixels_sent++;
		@(negedge clk);
	endtask

	// Hold the input off until every expected beat is in and the pipe is empty.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (sharp_queue.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_IMAGE_WIDTH) begin
			width_reg = val[WIDTH_REG_W-1:0];
		end else if (idx == REG_IMAGE_HEIGHT) begin
			height_reg = val[HEIGHT_REG_W-1:0];
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Send pixels until the raster position wraps back to the frame start.
	task automatic send_frame(input pix_style_t style, input bit with_pauses);
		do begin
			if (with_pauses && $urandom_range(0, 149) == 0) begin
				drain_results();
			end
			send_pixel(draw_pixel(style));
		end while (pos_col != 0 || pos_row != 0);
	endtask

	task automatic send_fixed_frame(input pixel_t centre, input pixel_t edge_px,
			input pixel_t corner);
		for (int i = 0; i < 9; i++) begin
			if (i == 4) begin
				send_pixel(centre);
			end else if (i % 2 == 1) begin
				send_pixel(edge_px);
			end else begin
				send_pixel(corner);
			end
		end
	endtask

	function automatic int pick_idle();
		int sel;
		sel = $urandom_range(0, 2);
		return (sel == 0) ? 0 : (sel == 1) ? 3 : 8;
	endfunction

	// Smallest frame, both clamp limits on every channel, unmapped register writes.
	task automatic test_kernel_extremes();
		src_gap_max = 8;
		snk_stall_max = 8;
		write_reg(REG_IMAGE_WIDTH, 13'd3);
		write_reg(REG_IMAGE_HEIGHT, 13'd3);
		write_reg(REG_UNMAPPED_2, '1);
		write_reg(REG_UNMAPPED_3, '1);
		send_fixed_frame(24'hFF00FF, 24'h00FF00, 24'hFFFFFF);
		send_fixed_frame(24'h00FF00, 24'hFF00FF, 24'h000000);
		drain_results();
	endtask

	// Register values below the minimum saturate to three.
	task automatic test_low_saturation();
		src_gap_max = 8;
		snk_stall_max = 8;
		write_reg(REG_IMAGE_WIDTH, 13'd0);
		write_reg(REG_IMAGE_HEIGHT, 13'd0);
		send_frame(PIX_MIXED, 1'b1);
		drain_results();
		write_reg(REG_IMAGE_WIDTH, 13'd2);
		write_reg(REG_IMAGE_HEIGHT, 13'd1);
		send_frame(PIX_RANDOM, 1'b1);
		drain_results();
	endtask

	// Random small frame sizes, random content and random idling on both sides.
	task automatic test_random_frames();
		int                    start;
		int                    w;
		logic [CFG_DATA_W-1:0] wdata;
		start = pixels_sent;
		while (pixels_sent - start < RANDOM_PIXELS) begin
			w = $urandom_range(3, 16);
			wdata = CFG_DATA_W'(w);
			// Bits above the width register are junk and must be ignored.
			wdata[CFG_DATA_W-1:WIDTH_REG_W] = 2'($urandom_range(0, 3));
			write_reg(REG_IMAGE_WIDTH, wdata);
			write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(3, 8)));
			src_gap_max = pick_idle();
			snk_stall_max = pick_idle();
			repeat ($urandom_range(1, 3)) begin
				send_frame(pix_style_t'($urandom_range(0, 3)), 1'b1);
			end
			drain_results();
		end
	endtask

	// Register writes part-way through a frame, with counters beyond the new limits.
	task automatic test_mid_frame_writes();
		src_gap_max = 8;
		snk_stall_max = 8;
		write_reg(REG_IMAGE_WIDTH, 13'd8);
		write_reg(REG_IMAGE_HEIGHT, 13'd6);
		repeat (20) send_pixel(draw_pixel(PIX_MIXED));
		drain_results();
		// Narrower row while the column count sits on the new last column.
		write_reg(REG_IMAGE_WIDTH, 13'd5);
		repeat (12) send_pixel(draw_pixel(PIX_MIXED));
		drain_results();
		// Fewer rows while the row count is already past the new last row.
		write_reg(REG_IMAGE_HEIGHT, 13'd3);
		send_frame(PIX_MIXED, 1'b0);
		drain_results();

		write_reg(REG_IMAGE_WIDTH, 13'd10);
		write_reg(REG_IMAGE_HEIGHT, 13'd4);
		repeat (7) send_pixel(draw_pixel(PIX_RANDOM));
		drain_results();
		write_reg(REG_IMAGE_WIDTH, 13'd4);
		send_frame(PIX_RANDOM, 1'b0);
		drain_results();

		write_reg(REG_IMAGE_WIDTH, 13'd3);
		write_reg(REG_IMAGE_HEIGHT, 13'd4096);
		repeat (12) send_pixel(draw_pixel(PIX_EXTREME));
		drain_results();
		write_reg(REG_IMAGE_HEIGHT, 13'd3);
		send_frame(PIX_EXTREME, 1'b0);
		drain_results();
	endtask

	// Wide rows: a width value above the maximum saturates rather than ending rows early.
	task automatic test_widest_rows();
		src_gap_max = 1;
		snk_stall_max = 1;
		write_reg(REG_IMAGE_WIDTH, 13'd2047);
		write_reg(REG_IMAGE_HEIGHT, 13'd3);
		repeat (40) send_pixel(draw_pixel(PIX_RANDOM));
		drain_results();
		// Narrow the row while the column count is far past the new last column.
		write_reg(REG_IMAGE_WIDTH, 13'd3);
		send_frame(PIX_MIXED, 1'b0);
		drain_results();
	endtask

	// Tall frame: a height value above the maximum saturates rather than ending early.
	task automatic test_tallest_frame();
		src_gap_max = 1;
		snk_stall_max = 1;
		write_reg(REG_IMAGE_WIDTH, 13'd3);
		write_reg(REG_IMAGE_HEIGHT, 13'd8191);
		repeat (30) send_pixel(draw_pixel(PIX_MIXED));
		drain_results();
		write_reg(REG_IMAGE_HEIGHT, 13'd3);
		send_frame(PIX_MIXED, 1'b0);
		drain_results();
	endtask

	// Output side: random stalls, drawn afresh after every accepted beat.
	always @(negedge clk) begin
		if (sink_hold > 0) begin
			m_tready <= 1'b0;
			sink_hold--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Compare each accepted output beat with the oldest expected one.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sink_hold = $urandom_range(0, snk_stall_max);
			if (sharp_queue.size() == 0) begin
				note_fault($sformatf("unexpected beat: tdata=%h tlast=%b", m_tdata, m_tlast));
			end else begin
				head_beat = sharp_queue.pop_front();
				if (m_tdata[7:0] !== head_beat.red || m_tdata[15:8] !== head_beat.green
						|| m_tdata[23:16] !== head_beat.blue || m_tlast !== head_beat.last) begin
					note_fault($sformatf(
						"mismatch: expected r=%h g=%h b=%h last=%b, got r=%h g=%h b=%h last=%b",
						head_beat.red, head_beat.green, head_beat.blue, head_beat.last,
						m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tlast));
				end
			end
		end
	end

	// Reset, the tests in turn, then the verdict.
	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		width_reg = WIDTH_REG_W'(WIDTH_RESET);
		height_reg = HEIGHT_REG_W'(HEIGHT_RESET);
		pos_col = '0;
		pos_row = '0;
		for (int i = 0; i < 6; i++) window_px[i] = '0;
		for (int i = 0; i < LINE_DEPTH; i++) line_mem[i] = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_kernel_extremes();
		test_low_saturation();
		test_random_frames();
		test_mid_frame_writes();
		test_widest_rows();
		test_tallest_frame();

		drain_results();
		repeat (16) @(negedge clk);
		if (fault_count == 0 && sharp_queue.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#20_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
